FILE: sv/g2r_pkg.sv
// Shared types, register codes and the 5x8 font table for the glyph renderer.
package g2r_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } cfg_index_t;

    localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd128;
    localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd160;
    localparam logic [10:0] SCREEN_MAX          = 11'd1024;
    localparam logic [9:0]  HEIGHT_SAT          = 10'd1023;

    // Printable code range and the substitute glyph
    localparam logic [7:0] CODE_LO    = 8'd32;
    localparam logic [7:0] CODE_HI    = 8'd126;
    localparam logic [7:0] CODE_SUBST = 8'd63;

    localparam int unsigned FONT_DEPTH = 95;
    localparam int unsigned FONT_AW    = 7;

    // Column index of the spacing column (after the five glyph columns)
    localparam logic [2:0] COL_LAST  = 3'd4;
    localparam logic [2:0] COL_SPACE = 3'd5;
    localparam logic [2:0] ROW_LAST  = 3'd7;

    // Five column bytes, column 0 first; bit 0 of a byte is the top row
    typedef logic [0:4][7:0] glyph_t;

    // One cell rectangle before clipping
    typedef struct packed {
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic [7:0]         w;
        logic [10:0]        h;
        logic [15:0]        color;
        logic [10:0]        advance;
        logic               last;
    } cell_t;

    localparam glyph_t FONT_ROM [FONT_DEPTH] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700,
        40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001C224100,
        40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
        40'h4261514946, 40'h2141454B31, 40'h1814127F10,
        40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h0056360000, 40'h0008142241, 40'h1414141414,
        40'h4122140800, 40'h0201510906, 40'h324979413E,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101,
        40'h3E41415132, 40'h7F0808087F, 40'h00417F4100,
        40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h7F2018207F, 40'h6314081463,
        40'h0304780403, 40'h6151494543, 40'h00007F4141,
        40'h0204081020, 40'h41417F0000, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7F48444438, 40'h3844444420, 40'h384444487F,
        40'h3854545418, 40'h087E090102, 40'h081454543C,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
        40'h007F102844, 40'h00417F4000, 40'h7C04180478,
        40'h7C08040478, 40'h3844444438, 40'h7C14141408,
        40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
        40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
        40'h4464544C44, 40'h0008364100, 40'h00007F0000,
        40'h0041360800, 40'h08082A1C08
    };

endpackage

FILE: sv/g2r_font_rom.sv
// Synchronous font ROM: one 5-column glyph per read, registered output.
module g2r_font_rom (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic [g2r_pkg::FONT_AW-1:0]  rd_addr,
    output g2r_pkg::glyph_t              rd_data
);

    g2r_pkg::glyph_t rd_data_reg;

    // Read the addressed glyph, hold it until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= g2r_pkg::FONT_ROM[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/g2r_rect_out.sv
// Clips one cell rectangle to the screen and holds it in the result register.
module g2r_rect_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [10:0]     screen_width,
    input  logic [10:0]     screen_height,
    input  logic            cell_valid,
    output logic            cell_ready,
    input  g2r_pkg::cell_t  cell_rect,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [9:0]      m_rect_x,
    output logic [9:0]      m_rect_y,
    output logic [7:0]      m_rect_w,
    output logic [9:0]      m_rect_h,
    output logic [15:0]     m_fill_color,
    output logic            m_visible,
    output logic [10:0]     m_advance,
    output logic            m_last
);

    logic        valid_reg;
    logic [9:0]  x_reg;
    logic [9:0]  y_reg;
    logic [7:0]  w_reg;
    logic [9:0]  h_reg;
    logic [15:0] color_reg;
    logic        vis_reg;
    logic [10:0] adv_reg;
    logic        last_reg;

    logic [10:0] sw;
    logic [10:0] sh;
    logic        vis;
    logic [10:0] rem_w;
    logic [10:0] rem_h;
    logic [10:0] w_ext;
    logic [10:0] w_clip;
    logic [10:0] h_clip;
    logic [9:0]  h_sat;
    logic [9:0]  x_next;
    logic [9:0]  y_next;
    logic [7:0]  w_next;
    logic [9:0]  h_next;
    logic        load;

    // Effective screen size: anything above the maximum acts as the maximum
    assign sw = (screen_width  > g2r_pkg::SCREEN_MAX) ? g2r_pkg::SCREEN_MAX : screen_width;
    assign sh = (screen_height > g2r_pkg::SCREEN_MAX) ? g2r_pkg::SCREEN_MAX : screen_height;

    // Visible when the corner lies on screen and the size is nonzero
    assign vis = !cell_rect.x[13] && !cell_rect.y[13] && (cell_rect.w != 8'd0)
                 && (cell_rect.h != 11'd0)
                 && (cell_rect.x < $signed({3'b000, sw}))
                 && (cell_rect.y < $signed({3'b000, sh}));

    // Clip width and height against the far screen edges
    always_comb begin
        rem_w  = sw - cell_rect.x[10:0];
        rem_h  = sh - cell_rect.y[10:0];
        w_ext  = {3'b000, cell_rect.w};
        w_clip = (w_ext > rem_w) ? rem_w : w_ext;
        h_clip = (cell_rect.h > rem_h) ? rem_h : cell_rect.h;
        h_sat  = h_clip[10] ? g2r_pkg::HEIGHT_SAT : h_clip[9:0];
        if (vis) begin
            x_next = cell_rect.x[9:0];
            y_next = cell_rect.y[9:0];
            w_next = w_clip[7:0];
            h_next = h_sat;
        end else begin
            x_next = 10'd0;
            y_next = 10'd0;
            w_next = 8'd0;
            h_next = 10'd0;
        end
    end

    assign cell_ready = !valid_reg || m_ready;
    assign load       = cell_valid && cell_ready;

    // Result register: load a new beat when empty or when the old one leaves
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cell_ready) begin
            valid_reg <= cell_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            color_reg <= cell_rect.color;
            vis_reg   <= vis;
            adv_reg   <= cell_rect.advance;
            last_reg  <= cell_rect.last;
        end
    end

    assign m_valid      = valid_reg;
    assign m_rect_x     = x_reg;
    assign m_rect_y     = y_reg;
    assign m_rect_w     = w_reg;
    assign m_rect_h     = h_reg;
    assign m_fill_color = color_reg;
    assign m_visible    = vis_reg;
    assign m_advance    = adv_reg;
    assign m_last       = last_reg;

endmodule

FILE: sv/glyph_to_rect_renderer_top.sv
// Top level of the glyph renderer: request slot, cell sequencer and config registers.
//
// Each accepted character request yields 41 rectangle beats, one per cycle while
// m_ready stays high (40 when fg_color equals bg_color, since the spacing column is
// dropped); a request passes through the slot and the working character registers
// before its first beat is registered. The cell sequencer walks the 5x8 glyph one
// cell a cycle, unless stalled, into a single result register. The glyph is
// fetched in one read of a synchronous font ROM when the request is accepted, and
// a one-entry request slot lets the next character be accepted while the current
// one is still being drawn, so characters stream without gaps as long as m_ready
// stays high. Screen size is written through the cfg port, which is always ready.
module glyph_to_rect_renderer_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [10:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    input  logic signed [11:0] s_origin_x,
    input  logic signed [11:0] s_origin_y,
    input  logic [15:0]        s_fg_color,
    input  logic [15:0]        s_bg_color,
    input  logic [7:0]         s_scale,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_rect_x,
    output logic [9:0]         m_rect_y,
    output logic [7:0]         m_rect_w,
    output logic [9:0]         m_rect_h,
    output logic [15:0]        m_fill_color,
    output logic               m_visible,
    output logic [10:0]        m_advance,
    output logic               m_last
);

    // Configuration registers
    logic [10:0] screen_width_reg;
    logic [10:0] screen_height_reg;

    // Request slot (glyph arrives from the ROM in the cycle after accept)
    logic               p_valid_reg;
    logic signed [11:0] p_ox_reg;
    logic signed [11:0] p_oy_reg;
    logic [15:0]        p_fg_reg;
    logic [15:0]        p_bg_reg;
    logic [7:0]         p_scale_reg;

    // Working character
    logic               w_valid_reg;
    g2r_pkg::glyph_t    w_glyph_reg;
    logic signed [13:0] w_oy_reg;
    logic [15:0]        w_fg_reg;
    logic [15:0]        w_bg_reg;
    logic [7:0]         w_scale_reg;
    logic               w_spacing_reg;
    logic [10:0]        w_adv_reg;
    logic [2:0]         col_reg;
    logic [2:0]         row_reg;
    logic signed [13:0] cell_x_reg;
    logic signed [13:0] cell_y_reg;

    logic                          s_accept;
    logic [7:0]                    code_sub;
    logic [g2r_pkg::FONT_AW-1:0]   rom_addr;
    g2r_pkg::glyph_t               rom_data;
    logic                          cell_ready;
    logic                          emit;
    logic                          w_free;
    logic                          p_move;
    logic                          is_space;
    logic                          is_last;
    logic [2:0]                    col_idx;
    logic                          cur_bit;
    logic signed [13:0]            scale_s;
    g2r_pkg::cell_t                cell_rect;

    assign cfg_ready = 1'b1;

    // Write screen size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= g2r_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg <= g2r_pkg::SCREEN_HEIGHT_RESET;
        end else if (cfg_valid) begin
            case (g2r_pkg::cfg_index_t'(cfg_index))
                g2r_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                g2r_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Map unprintable codes to the substitute glyph and form the ROM address
    always_comb begin
        if (s_char_code < g2r_pkg::CODE_LO || s_char_code > g2r_pkg::CODE_HI) begin
            code_sub = g2r_pkg::CODE_SUBST;
        end else begin
            code_sub = s_char_code;
        end
        rom_addr = 7'(code_sub - g2r_pkg::CODE_LO);
    end

    g2r_font_rom u_font_rom (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    // Handshake between slot, sequencer and result register
    assign is_space = (col_reg == g2r_pkg::COL_SPACE);
    assign is_last  = is_space ||
                      (!w_spacing_reg && col_reg == g2r_pkg::COL_LAST &&
                       row_reg == g2r_pkg::ROW_LAST);
    assign emit     = w_valid_reg && cell_ready;
    assign w_free   = !w_valid_reg || (emit && is_last);
    assign p_move   = p_valid_reg && w_free;
    assign s_ready  = !p_valid_reg || p_move;
    assign s_accept = s_valid && s_ready;

    // Hold the accepted request until the sequencer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (s_accept) begin
            p_valid_reg <= 1'b1;
        end else if (p_move) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_ox_reg    <= s_origin_x;
            p_oy_reg    <= s_origin_y;
            p_fg_reg    <= s_fg_color;
            p_bg_reg    <= s_bg_color;
            p_scale_reg <= s_scale;
        end
    end

    // Current cell: glyph bit, colour and unclipped geometry
    assign col_idx = is_space ? 3'd0 : col_reg;
    assign cur_bit = w_glyph_reg[col_idx][row_reg];
    assign scale_s = $signed({6'd0, w_scale_reg});

    always_comb begin
        cell_rect.x       = cell_x_reg;
        cell_rect.y       = cell_y_reg;
        cell_rect.advance = w_adv_reg;
        cell_rect.last    = is_last;
        if (is_space) begin
            cell_rect.w     = (w_scale_reg != 8'd0) ? 8'd1 : 8'd0;
            cell_rect.h     = {w_scale_reg, 3'b000};
            cell_rect.color = w_bg_reg;
        end else begin
            cell_rect.w     = w_scale_reg;
            cell_rect.h     = {3'b000, w_scale_reg};
            cell_rect.color = cur_bit ? w_fg_reg : w_bg_reg;
        end
    end

    // Working character valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else if (w_free) begin
            w_valid_reg <= p_valid_reg;
        end
    end

    // Load a new character or advance row-inner, column-outer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= 3'd0;
            row_reg <= 3'd0;
        end else if (p_move) begin
            col_reg <= 3'd0;
            row_reg <= 3'd0;
        end else if (emit && !is_last) begin
            if (row_reg == g2r_pkg::ROW_LAST) begin
                row_reg <= 3'd0;
                col_reg <= col_reg + 3'd1;
            end else begin
                row_reg <= row_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_move) begin
            w_glyph_reg   <= rom_data;
            w_oy_reg      <= 14'(p_oy_reg);
            w_fg_reg      <= p_fg_reg;
            w_bg_reg      <= p_bg_reg;
            w_scale_reg   <= p_scale_reg;
            w_spacing_reg <= (p_fg_reg != p_bg_reg);
            w_adv_reg     <= {1'b0, p_scale_reg, 2'b00} + {2'b00, p_scale_reg, 1'b0};
            cell_x_reg    <= 14'(p_ox_reg);
            cell_y_reg    <= 14'(p_oy_reg);
        end else if (emit && !is_last) begin
            if (row_reg == g2r_pkg::ROW_LAST) begin
                cell_x_reg <= cell_x_reg + scale_s;
                cell_y_reg <= w_oy_reg;
            end else begin
                cell_y_reg <= cell_y_reg + scale_s;
            end
        end
    end

    g2r_rect_out u_rect_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .cell_valid    (w_valid_reg),
        .cell_ready    (cell_ready),
        .cell_rect     (cell_rect),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rect_x      (m_rect_x),
        .m_rect_y      (m_rect_y),
        .m_rect_w      (m_rect_w),
        .m_rect_h      (m_rect_h),
        .m_fill_color  (m_fill_color),
        .m_visible     (m_visible),
        .m_advance     (m_advance),
        .m_last        (m_last)
    );

    // An accepted beat always lands in the request slot
    a_accept_fills_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> p_valid_reg)
        else $error("accepted request did not reach the slot");

    // The sequencer never walks past the spacing column
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        w_valid_reg |-> (col_reg <= g2r_pkg::COL_SPACE))
        else $error("column counter out of range");

    // The spacing column is only reached when the colours differ
    a_space_needs_colors: assert property (@(posedge aclk) disable iff (!aresetn)
        w_valid_reg && is_space |-> w_spacing_reg)
        else $error("spacing column drawn with equal colours");

    // A visible result always has a nonzero size
    a_visible_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_visible |-> (m_rect_w != 8'd0) && (m_rect_h != 10'd0))
        else $error("visible rectangle with empty size");

endmodule
